@@ rtl/ptmap_pkg.sv @@
`timescale 1ns / 1ps

package ptmap_pkg;

    localparam int ENTRIES_PER_TABLE = 512;
    localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
    localparam int VA_W              = 48;
    localparam int PA_W              = 52;
    localparam int ENTRY_W           = 64;
    localparam int PAGE_SHIFT        = 12;
    localparam int PFN_W             = PA_W - PAGE_SHIFT;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_WRITE   = 1;
    localparam int BIT_HUGE    = 7;

    localparam logic ACT_MAP    = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    localparam logic [1:0] LVL_PML4 = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_ZERO,
        ST_LINK
    } t_state;

    typedef enum logic [1:0] {
        STATUS_DONE     = 2'd0,
        STATUS_NO_FRAME = 2'd1,
        STATUS_ABSENT   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_ZERO,
        WR_LEAF,
        WR_LINK
    } t_wr_sel;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_LEAF,
        RES_ENTRY
    } t_res_sel;

    typedef struct packed {
        logic     load_item;
        logic     mem_rd;
        t_wr_sel  wr_sel;
        logic     alloc;
        logic     descend_dec;
        logic     descend_new;
        logic     res_load;
        t_status  res_status;
        t_res_sel res_sel;
    } t_cmd;

    typedef struct packed {
        logic action;
        logic present;
        logic entry_huge;
        logic leaf_huge;
        logic level_pd;
        logic level_pt;
        logic decode_ok;
        logic frames_left;
        logic nf_dirty;
        logic clear_last;
        logic sweep_last;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/ptmap_ctrl.sv @@
`timescale 1ns / 1ps

module ptmap_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ptmap_pkg::t_dp_stat i_stat,
    output ptmap_pkg::t_cmd     o_cmd
);
    import ptmap_pkg::*;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        cmd            = '0;
        cmd.wr_sel     = WR_NONE;
        cmd.res_status = STATUS_DONE;
        cmd.res_sel    = RES_ZERO;
        n_state        = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                cmd.wr_sel = WR_CLEAR;
                if (i_stat.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_item = 1'b1;
                    n_state       = ST_READ;
                end
            end
            ST_READ: begin
                cmd.mem_rd = 1'b1;
                n_state    = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_stat.action == ACT_MAP) begin
                    priority if ((i_stat.level_pd && i_stat.leaf_huge) || i_stat.level_pt) begin
                        if (i_stat.out_free) begin
                            cmd.wr_sel     = WR_LEAF;
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STATUS_DONE;
                            cmd.res_sel    = RES_LEAF;
                            n_state        = ST_IDLE;
                        end
                    end else if (!i_stat.present) begin
                        if (!i_stat.frames_left) begin
                            if (i_stat.out_free) begin
                                cmd.res_load   = 1'b1;
                                cmd.res_status = STATUS_NO_FRAME;
                                n_state        = ST_IDLE;
                            end
                        end else begin
                            cmd.alloc = 1'b1;
                            n_state   = i_stat.nf_dirty ? ST_ZERO : ST_LINK;
                        end
                    end else if (i_stat.decode_ok) begin
                        cmd.descend_dec = 1'b1;
                        n_state         = ST_READ;
                    end else begin
                        if (i_stat.out_free) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STATUS_NO_FRAME;
                            n_state        = ST_IDLE;
                        end
                    end
                end else begin
                    priority if (!i_stat.present) begin
                        if (i_stat.out_free) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STATUS_ABSENT;
                            n_state        = ST_IDLE;
                        end
                    end else if ((i_stat.level_pd && i_stat.entry_huge) || i_stat.level_pt) begin
                        if (i_stat.out_free) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STATUS_DONE;
                            cmd.res_sel    = RES_ENTRY;
                            n_state        = ST_IDLE;
                        end
                    end else if (i_stat.decode_ok) begin
                        cmd.descend_dec = 1'b1;
                        n_state         = ST_READ;
                    end else begin
                        if (i_stat.out_free) begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = STATUS_NO_FRAME;
                            n_state        = ST_IDLE;
                        end
                    end
                end
            end
            ST_ZERO: begin
                cmd.wr_sel = WR_ZERO;
                if (i_stat.sweep_last) begin
                    n_state = ST_LINK;
                end
            end
            ST_LINK: begin
                cmd.wr_sel      = WR_LINK;
                cmd.descend_new = 1'b1;
                n_state         = ST_READ;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_ready = (r_state == ST_IDLE);

endmodule

@@ rtl/ptmap_dp.sv @@
`timescale 1ns / 1ps

module ptmap_dp #(
    parameter int TABLE_FRAMES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ptmap_pkg::t_cmd            i_cmd,
    output ptmap_pkg::t_dp_stat        o_stat,
    input  logic                       i_cfg_we,
    input  logic [ptmap_pkg::PA_W-1:0] i_cfg_data,
    input  logic                       i_action,
    input  logic [ptmap_pkg::VA_W-1:0] i_virtual_address,
    input  logic [ptmap_pkg::PA_W-1:0] i_physical_address,
    input  logic [ptmap_pkg::ENTRY_W-1:0] i_entry_flags,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_status,
    output logic [ptmap_pkg::ENTRY_W-1:0] o_entry_value,
    output logic [1:0]                 o_level_reached
);
    import ptmap_pkg::*;

    localparam int FW    = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
    localparam int NFW   = $clog2(TABLE_FRAMES + 1);
    localparam int AW    = FW + IDX_W;
    localparam int DEPTH = TABLE_FRAMES * ENTRIES_PER_TABLE;

    // table store
    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    logic [PA_W-1:0]    r_base;
    logic               r_action;
    logic [VA_W-1:0]    r_va;
    logic [PA_W-1:0]    r_pa;
    logic [ENTRY_W-1:0] r_flags;
    logic [1:0]         r_level;
    logic [FW-1:0]      r_frame;
    logic [FW-1:0]      r_new_frame;
    logic [NFW-1:0]     r_nf;
    logic [TABLE_FRAMES-1:0] r_dirty;
    logic [AW-1:0]      r_clr_cnt;
    logic [IDX_W-1:0]   r_sweep_cnt;

    logic               r_out_valid;
    t_status            r_out_status;
    logic [ENTRY_W-1:0] r_out_value;
    logic [1:0]         r_out_level;

    logic [IDX_W-1:0]   idx;
    logic [AW-1:0]      slot_addr;
    logic [AW-1:0]      mem_addr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_we;
    logic [ENTRY_W-1:0] leaf;
    logic [PFN_W-1:0]   link_pfn;
    logic [PFN_W-1:0]   diff;
    logic               decode_ok;
    logic               frames_left;
    logic               out_free;

    always_comb begin
        unique case (r_level)
            LVL_PML4: idx = r_va[47:39];
            LVL_PDPT: idx = r_va[38:30];
            LVL_PD:   idx = r_va[29:21];
            LVL_PT:   idx = r_va[20:12];
            default:  idx = r_va[20:12];
        endcase
    end

    assign slot_addr   = {r_frame, idx};
    assign leaf        = {{(ENTRY_W - PA_W){1'b0}}, r_pa} | r_flags;
    assign link_pfn    = r_base[PA_W-1:PAGE_SHIFT] + PFN_W'(r_new_frame);
    assign diff        = r_rdata[PA_W-1:PAGE_SHIFT] - r_base[PA_W-1:PAGE_SHIFT];
    assign decode_ok   = (diff < PFN_W'(TABLE_FRAMES));
    assign frames_left = (r_nf < NFW'(TABLE_FRAMES));
    assign out_free    = !r_out_valid || i_out_ready;
    assign mem_we      = (i_cmd.wr_sel != WR_NONE);

    always_comb begin
        mem_addr  = slot_addr;
        mem_wdata = '0;
        unique case (i_cmd.wr_sel)
            WR_CLEAR: mem_addr = r_clr_cnt;
            WR_ZERO:  mem_addr = {r_new_frame, r_sweep_cnt};
            WR_LEAF:  mem_wdata = leaf;
            WR_LINK: begin
                mem_wdata = {{(ENTRY_W - PA_W){1'b0}}, link_pfn, {PAGE_SHIFT{1'b0}}};
                mem_wdata[BIT_PRESENT] = 1'b1;
                mem_wdata[BIT_WRITE]   = 1'b1;
            end
            default: mem_addr = slot_addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    // item and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action <= i_action;
            r_va     <= i_virtual_address;
            r_pa     <= i_physical_address;
            r_flags  <= i_entry_flags;
            r_level  <= LVL_PML4;
            r_frame  <= '0;
        end else if (i_cmd.descend_dec) begin
            r_frame  <= diff[FW-1:0];
            r_level  <= r_level + 2'd1;
        end else if (i_cmd.descend_new) begin
            r_frame  <= r_new_frame;
            r_level  <= r_level + 2'd1;
        end
        if (i_cmd.alloc) begin
            r_new_frame <= r_nf[FW-1:0];
            r_sweep_cnt <= '0;
        end else if (i_cmd.wr_sel == WR_ZERO) begin
            r_sweep_cnt <= r_sweep_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_nf      <= NFW'(1);
            r_dirty   <= '0;
            r_clr_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            if (i_cmd.alloc) begin
                r_nf <= r_nf + 1'b1;
            end
            if (i_cmd.wr_sel == WR_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.wr_sel == WR_LEAF || i_cmd.wr_sel == WR_LINK) begin
                r_dirty[r_frame] <= 1'b1;
            end else if (i_cmd.wr_sel == WR_ZERO && r_sweep_cnt == '1) begin
                r_dirty[r_new_frame] <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_status <= i_cmd.res_status;
            r_out_level  <= r_level;
            unique case (i_cmd.res_sel)
                RES_LEAF:  r_out_value <= leaf;
                RES_ENTRY: r_out_value <= r_rdata;
                default:   r_out_value <= '0;
            endcase
        end
    end

    always_comb begin
        o_stat.action      = r_action;
        o_stat.present     = r_rdata[BIT_PRESENT];
        o_stat.entry_huge  = r_rdata[BIT_HUGE];
        o_stat.leaf_huge   = r_flags[BIT_HUGE];
        o_stat.level_pd    = (r_level == LVL_PD);
        o_stat.level_pt    = (r_level == LVL_PT);
        o_stat.decode_ok   = decode_ok;
        o_stat.frames_left = frames_left;
        o_stat.nf_dirty    = frames_left && r_dirty[r_nf[FW-1:0]];
        o_stat.clear_last  = (r_clr_cnt == AW'(DEPTH - 1));
        o_stat.sweep_last  = (r_sweep_cnt == '1);
        o_stat.out_free    = out_free;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_entry_value   = r_out_value;
    assign o_level_reached = r_out_level;

`ifndef ASSERT_OFF
    a_nf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nf <= NFW'(TABLE_FRAMES))
        else $error("frame allocator ran past the store");

    a_alloc_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |-> frames_left)
        else $error("frame handed out with none left");

    a_alloc_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |=> (r_nf == $past(r_nf) + 1'b1))
        else $error("allocator did not advance by one frame");

    a_res_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.res_load |-> out_free)
        else $error("result overwrote an untaken transfer");
`endif

endmodule

@@ rtl/four_level_page_table_mapper.sv @@
`timescale 1ns / 1ps
// per item: the accept, then per table level a memory read followed by an evaluate;
// each fresh table frame adds a link write, plus a wipe of the frame if it was written
// before being handed out; a finished item waits in evaluate while the result is untaken
// throughput: one item at a time through the single-port table store
// reset: synchronous active-low; clears the allocator and base register, then zeroes the
// store at one entry a cycle with input ready held low

module four_level_page_table_mapper #(
    parameter int TABLE_FRAMES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ptmap_pkg::PA_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_action,
    input  logic [ptmap_pkg::VA_W-1:0]    i_virtual_address,
    input  logic [ptmap_pkg::PA_W-1:0]    i_physical_address,
    input  logic [ptmap_pkg::ENTRY_W-1:0] i_entry_flags,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic [ptmap_pkg::ENTRY_W-1:0] o_entry_value,
    output logic [1:0]                    o_level_reached
);
    import ptmap_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;

    ptmap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ptmap_dp #(
        .TABLE_FRAMES (TABLE_FRAMES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_action           (i_action),
        .i_virtual_address  (i_virtual_address),
        .i_physical_address (i_physical_address),
        .i_entry_flags      (i_entry_flags),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_entry_value      (o_entry_value),
        .o_level_reached    (o_level_reached)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import ptmap_pkg::*;

    localparam int FRAMES        = 16;
    localparam int CYCLE_LIMIT   = 600_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 24;
    localparam int POOL_SIZE     = 48;

    localparam logic [ENTRY_W-1:0] ADDR_MASK = 64'h000f_ffff_ffff_f000;
    localparam logic [ENTRY_W-1:0] WRAP52    = 64'h000f_ffff_ffff_ffff;
    localparam logic [ENTRY_W-1:0] LINK_BITS =
        (64'd1 << BIT_PRESENT) | (64'd1 << BIT_WRITE);
    localparam logic [ENTRY_W-1:0] FLAGS_RW      = LINK_BITS;
    localparam logic [ENTRY_W-1:0] FLAGS_HUGE_RW = LINK_BITS | (64'd1 << BIT_HUGE);

    typedef struct packed {
        t_status            status;
        logic [ENTRY_W-1:0] value;
        logic [1:0]         level;
    } t_walk_result;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [PA_W-1:0]    cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               in_action;
    logic [VA_W-1:0]    in_va;
    logic [PA_W-1:0]    in_pa;
    logic [ENTRY_W-1:0] in_flags;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         res_status;
    logic [ENTRY_W-1:0] res_entry;
    logic [1:0]         res_level;

    // own copy of the table store, allocator and base register
    logic [ENTRY_W-1:0] table_mem [FRAMES*ENTRIES_PER_TABLE];
    int                 free_frame;
    logic [PA_W-1:0]    region_base;

    t_walk_result       pending_results[$];
    logic [VA_W-1:0]    known_pages[$];
    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 stall_left = 0;
    bit                 send_gaps;
    bit                 recv_stalls;

    four_level_page_table_mapper #(
        .TABLE_FRAMES(FRAMES)
    ) u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_action          (in_action),
        .i_virtual_address (in_va),
        .i_physical_address(in_pa),
        .i_entry_flags     (in_flags),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_status          (res_status),
        .o_entry_value     (res_entry),
        .o_level_reached   (res_level)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [ENTRY_W-1:0] frame_address(int f);
        return ((64'(region_base) & ADDR_MASK) + (64'(f) << PAGE_SHIFT)) & ADDR_MASK;
    endfunction

    // frame named by a table pointer, or -1 when it lies outside the store
    function automatic int frame_index(logic [ENTRY_W-1:0] e);
        logic [ENTRY_W-1:0] d;
        d = (((e & ADDR_MASK) - (64'(region_base) & ADDR_MASK)) & WRAP52) >> PAGE_SHIFT;
        if (d >= 64'(FRAMES)) return -1;
        return int'(d);
    endfunction

    function automatic int entry_slot(int frame, logic [VA_W-1:0] va, int lvl);
        return frame * ENTRIES_PER_TABLE
            + int'((va >> (PAGE_SHIFT + IDX_W * (3 - lvl))) & VA_W'(ENTRIES_PER_TABLE - 1));
    endfunction

    function automatic t_walk_result walk_tables(logic act, logic [VA_W-1:0] va,
                                                 logic [PA_W-1:0] pa,
                                                 logic [ENTRY_W-1:0] fl);
        logic [ENTRY_W-1:0] leaf;
        logic [ENTRY_W-1:0] entry;
        int                 frame;
        int                 s;
        leaf  = 64'(pa) | fl;
        frame = 0;
        if (act == ACT_MAP) begin
            for (int lvl = 0; lvl < 3; lvl++) begin
                s = entry_slot(frame, va, lvl);
                if (lvl == 2 && fl[BIT_HUGE]) begin
                    table_mem[s] = leaf;
                    return '{STATUS_DONE, leaf, LVL_PD};
                end
                if (!table_mem[s][BIT_PRESENT]) begin
                    if (free_frame >= FRAMES) return '{STATUS_NO_FRAME, '0, 2'(lvl)};
                    for (int i = 0; i < ENTRIES_PER_TABLE; i++)
                        table_mem[free_frame * ENTRIES_PER_TABLE + i] = '0;
                    table_mem[s] = frame_address(free_frame) | LINK_BITS;
                    free_frame++;
                end
                frame = frame_index(table_mem[s]);
                if (frame < 0) return '{STATUS_NO_FRAME, '0, 2'(lvl)};
            end
            table_mem[entry_slot(frame, va, 3)] = leaf;
            return '{STATUS_DONE, leaf, LVL_PT};
        end
        for (int lvl = 0; lvl < 3; lvl++) begin
            entry = table_mem[entry_slot(frame, va, lvl)];
            if (!entry[BIT_PRESENT]) return '{STATUS_ABSENT, '0, 2'(lvl)};
            if (lvl == 2 && entry[BIT_HUGE]) return '{STATUS_DONE, entry, LVL_PD};
            frame = frame_index(entry);
            if (frame < 0) return '{STATUS_NO_FRAME, '0, 2'(lvl)};
        end
        entry = table_mem[entry_slot(frame, va, 3)];
        if (!entry[BIT_PRESENT]) return '{STATUS_ABSENT, '0, LVL_PT};
        return '{STATUS_DONE, entry, LVL_PT};
    endfunction

    task automatic send_item(logic act, logic [VA_W-1:0] va, logic [PA_W-1:0] pa,
                             logic [ENTRY_W-1:0] fl);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_va     <= va;
        in_pa     <= pa;
        in_flags  <= fl;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        pending_results.push_back(walk_tables(act, va, pa, fl));
        if (act == ACT_MAP && !fl[BIT_HUGE]) begin
            known_pages.push_back(va);
            if (known_pages.size() > POOL_SIZE)
                known_pages.delete($urandom_range(0, POOL_SIZE - 1));
        end
    endtask

    task automatic write_table_base(logic [PA_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        region_base = value;
    endtask

    task automatic test_basic_walks();
        send_item(ACT_LOOKUP, 48'h0000_0000_0000, '0, '0);
        send_item(ACT_MAP, 48'h0000_0000_0000, 52'hf_ffff_ffff_f000,
                  64'h8000_0000_0000_0000 | FLAGS_RW);
        send_item(ACT_LOOKUP, 48'h0000_0000_0fff, '0, '0);
        send_item(ACT_LOOKUP, 48'h0000_0000_1000, '0, '0);
        send_item(ACT_LOOKUP, 48'h0000_00a0_0000, '0, '0);
        send_item(ACT_LOOKUP, 48'h0000_c000_0000, '0, '0);
        // huge leaf, then a small-page map that tries to walk through it
        send_item(ACT_MAP, 48'h0000_0020_0000, 52'h0_0000_0020_0000, FLAGS_HUGE_RW);
        send_item(ACT_LOOKUP, 48'h0000_002a_bcde, '0, '0);
        send_item(ACT_MAP, 48'h0000_0020_1000, 52'h0_0000_0012_3000, FLAGS_RW);
        // huge leaf that points at a frame not yet handed out
        send_item(ACT_MAP, 48'h0000_0040_0000, PA_W'(frame_address(5)), FLAGS_HUGE_RW);
        send_item(ACT_MAP, 48'h0000_0040_1000, 52'h0_0000_0012_3000, 64'h7);
        send_item(ACT_LOOKUP, 48'h0000_0040_1000, '0, '0);
        // leaf without the present bit
        send_item(ACT_MAP, 48'h0000_0000_2000, 52'h0_0000_0000_3000, '0);
        send_item(ACT_LOOKUP, 48'h0000_0000_2000, '0, '0);
        // huge leaf over an existing directory link
        send_item(ACT_MAP, 48'h0000_0060_0000, 52'h0_0000_0000_7000, FLAGS_RW);
        send_item(ACT_MAP, 48'h0000_0060_0000, 52'h0_0000_4000_0000,
                  64'h8000_0000_0000_0000 | FLAGS_HUGE_RW);
        send_item(ACT_LOOKUP, 48'h0000_0060_0abc, '0, '0);
        // new top-level slot reuses the frame written above, which must come back wiped
        send_item(ACT_MAP, 48'h0080_0000_0000, 52'h0_0000_abcd_e000, FLAGS_RW);
        send_item(ACT_LOOKUP, 48'h0080_4000_0000, '0, '0);
        send_item(ACT_MAP, 48'hffff_ffff_ffff, '1, '1);
        send_item(ACT_LOOKUP, 48'hffff_ffff_ffff, '0, '0);
    endtask

    task automatic test_random_traffic(int count);
        logic            act;
        logic [VA_W-1:0] va;
        logic [VA_W-1:0] page;
        logic [PA_W-1:0] pa;
        logic [ENTRY_W-1:0] fl;
        int              pick;
        repeat (count) begin
            act  = $urandom_range(0, 1) ? ACT_LOOKUP : ACT_MAP;
            pick = $urandom_range(0, 9);
            va   = VA_W'({$urandom, $urandom});
            if (known_pages.size() != 0 && pick < 8) begin
                page = known_pages[$urandom_range(0, known_pages.size() - 1)];
                if (pick < 4) va[VA_W-1:12] = page[VA_W-1:12];
                else if (pick < 6) va[VA_W-1:21] = page[VA_W-1:21];
                else va[VA_W-1:30] = page[VA_W-1:30];
            end
            fl = {$urandom, $urandom};
            fl[BIT_HUGE]    = ($urandom_range(0, 19) == 0);
            fl[BIT_PRESENT] = ($urandom_range(0, 4) != 0);
            pa = PA_W'({$urandom, $urandom});
            if ($urandom_range(0, 4) != 0) pa[PAGE_SHIFT-1:0] = '0;
            if (fl[BIT_HUGE] && $urandom_range(0, 1))
                pa = PA_W'(frame_address($urandom_range(0, FRAMES - 1)));
            send_item(act, va, pa, fl);
        end
    endtask

    task automatic test_moved_region_base();
        // existing links now point below the store
        write_table_base(52'h0_0000_0010_0000);
        send_item(ACT_LOOKUP, 48'h0000_0000_0000, '0, '0);
        send_item(ACT_MAP, 48'h0000_0000_5000, 52'h0_0000_0000_5000, FLAGS_RW);
        // top of the address space, frames wrap through zero
        write_table_base('1);
        test_random_traffic(250);
        write_table_base(PA_W'({$urandom, $urandom}));
        test_random_traffic(250);
    endtask

    task automatic test_frame_exhaustion();
        int spare;
        int root_free;
        spare = 0;
        while (free_frame < FRAMES && spare < 16) begin
            send_item(ACT_MAP, VA_W'(256 + spare) << 30, 52'h0_0000_0000_9000, FLAGS_RW);
            spare++;
        end
        root_free = -1;
        for (int i = ENTRIES_PER_TABLE - 1; i >= 0; i--)
            if (!table_mem[i][BIT_PRESENT]) root_free = i;
        if (root_free >= 0)
            send_item(ACT_MAP, VA_W'(root_free) << 39, 52'h0_0000_0000_9000, FLAGS_RW);
        send_item(ACT_MAP, 48'h007f_c000_0000, 52'h0_0000_0000_9000, FLAGS_RW);
        send_item(ACT_MAP, 48'h0000_3fe0_0000, 52'h0_0000_0000_9000, FLAGS_RW);
        send_item(ACT_LOOKUP, 48'h0000_3fe0_0000, '0, '0);
    endtask

    task automatic test_back_to_back();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        test_random_traffic(450);
    endtask

    always @(posedge clk) begin : result_check
        t_walk_result want;
        if (rst_n && out_ready && out_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: status %0d entry %h level %0d",
                       res_status, res_entry, res_level);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, res_status);
                    error_count++;
                end
                if (res_entry !== want.value) begin
                    $error("entry_value: expected %h, actual %h", want.value, res_entry);
                    error_count++;
                end
                if (res_level !== want.level) begin
                    $error("level_reached: expected %0d, actual %0d", want.level, res_level);
                    error_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 14);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        free_frame  = 1;
        region_base = '0;
        for (int i = 0; i < FRAMES * ENTRIES_PER_TABLE; i++) table_mem[i] = '0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_action <= ACT_MAP;
        in_va     <= '0;
        in_pa     <= '0;
        in_flags  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // store is wiped after reset before the first transfer
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        write_table_base('0);

        test_basic_walks();
        test_moved_region_base();
        write_table_base('0);
        test_random_traffic(700);
        test_frame_exhaustion();
        test_back_to_back();

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
